[design/wilson_lower_bound_unit_defines.svh]
// assertion macros shared by the checker
`ifndef WILSON_LOWER_BOUND_UNIT_DEFINES_SVH
`define WILSON_LOWER_BOUND_UNIT_DEFINES_SVH

// same-cycle implication
`define WLB_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wlb assertion failed");

// next-cycle implication
`define WLB_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wlb assertion failed");

`endif

[design/wlb_pkg.sv]
package wlb_pkg;

  // field widths
  localparam int CNT_W  = 32;
  localparam int FRAC_W = 32;
  localparam int Z_W    = 24;
  localparam logic [Z_W-1:0] Z_RESET = 24'd1960000;
  localparam int Z2_W   = 2 * Z_W;

  // ppm squared, ten to the twelfth
  localparam int E_W = 40;
  localparam logic [E_W-1:0] PPM_SQ = 40'd1000000000000;

  // intermediate widths
  localparam int SD_W  = 2 * CNT_W;
  localparam int SE_W  = CNT_W + E_W;
  localparam int NZ_W  = CNT_W + Z2_W;
  localparam int Q_W   = SD_W + E_W + 1;
  localparam int HW    = Z_W;
  localparam int QCH   = (Q_W + HW - 1) / HW;
  localparam int ROW_W = 3 * HW;
  localparam int P_W   = Q_W + Z2_W;
  localparam int M_W   = P_W + 2 * FRAC_W;
  localparam int U_W   = CNT_W + E_W + Z2_W + 2 * FRAC_W + 2;
  localparam int SQ_W  = (U_W + 1) / 2;
  localparam int RAD_W = 2 * SQ_W;
  localparam int RM_W  = SQ_W + 2;
  localparam int T_W   = SQ_W + 1;
  localparam int C_W   = CNT_W + E_W + 2;
  localparam int X_W   = FRAC_W + C_W;
  localparam int QO_W  = FRAC_W + 1;

  // numerator and denominator travelling alongside each request
  typedef struct packed {
    logic           vld;
    logic           bad;
    logic [X_W-1:0] x;
    logic [C_W-1:0] c;
  } side_t;

  // division by the trial count
  typedef struct packed {
    side_t            sd;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] rem;
    logic [M_W-1:0]   sh;
  } div_t;

  // square root digit recurrence
  typedef struct packed {
    side_t             sd;
    logic [RAD_W-1:0]  rad;
    logic [RM_W-1:0]   rem;
    logic [SQ_W-1:0]   root;
  } sqrt_t;

  // final quotient
  typedef struct packed {
    side_t            sd;
    logic [X_W-1:0]   rem;
    logic [X_W-1:0]   dv;
    logic [QO_W-1:0]  q;
  } qd_t;

  typedef struct packed {
    logic [FRAC_W-1:0] frac;
    logic              bad;
  } res_t;

endpackage

[design/wlb_in_if.sv]
interface wlb_in_if;
  logic                       valid;
  logic                       ready;
  logic [wlb_pkg::CNT_W-1:0]  success_count;
  logic [wlb_pkg::CNT_W-1:0]  trial_count;

  modport source (output valid, success_count, trial_count, input ready);
  modport sink (input valid, success_count, trial_count, output ready);
endinterface

[design/wlb_out_if.sv]
interface wlb_out_if;
  logic                        valid;
  logic                        ready;
  logic [wlb_pkg::FRAC_W-1:0]  lower_bound_frac;
  logic                        input_invalid;

  modport source (output valid, lower_bound_frac, input_invalid, input ready);
  modport sink (input valid, lower_bound_frac, input_invalid, output ready);
endinterface

[design/wlb_front.sv]
module wlb_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     acc,
  input  logic [wlb_pkg::CNT_W-1:0] s,
  input  logic [wlb_pkg::CNT_W-1:0] n,
  input  logic [wlb_pkg::Z_W-1:0]   z,
  output wlb_pkg::div_t             f_o
);

  // stage valids
  logic [6:0] v_r;

  // stage 1
  logic                      bad1_r, bad2_r, bad3_r, bad4_r, bad5_r, bad6_r, bad7_r;
  logic [wlb_pkg::CNT_W-1:0] s1_r, n1_r, d1_r;
  logic [wlb_pkg::Z2_W-1:0]  z2_1_r;
  // stage 2
  logic [wlb_pkg::SD_W-1:0]         sd2_r;
  logic [wlb_pkg::CNT_W+wlb_pkg::HW-1:0] nzl2_r, nzh2_r;
  logic [wlb_pkg::SE_W-1:0]         se2_r, ne2_r;
  logic [wlb_pkg::Z2_W-1:0]         z2_2_r;
  logic [wlb_pkg::CNT_W-1:0]        n2_r;
  // stage 3
  logic [wlb_pkg::SE_W-1:0]  bl3_r, bh3_r;
  logic [wlb_pkg::NZ_W-1:0]  nz3_r;
  logic [wlb_pkg::X_W-1:0]   x3_r, x4_r, x5_r, x6_r, x7_r;
  logic [wlb_pkg::C_W-1:0]   c3_r, c4_r, c5_r, c6_r, c7_r;
  logic [wlb_pkg::Z2_W-1:0]  z2_3_r, z2_4_r;
  logic [wlb_pkg::CNT_W-1:0] n3_r, n4_r, n5_r, n6_r, n7_r;
  // stage 4
  logic [wlb_pkg::Q_W-1:0]   q4_r;
  // stage 5 and 6
  logic [2*wlb_pkg::HW-1:0]  ppl5_r [wlb_pkg::QCH];
  logic [2*wlb_pkg::HW-1:0]  pph5_r [wlb_pkg::QCH];
  logic [wlb_pkg::ROW_W-1:0] row6_r [wlb_pkg::QCH];
  // stage 7
  logic [wlb_pkg::P_W-1:0]   p7_r;

  logic [wlb_pkg::QCH*wlb_pkg::HW-1:0] qpad;
  logic [wlb_pkg::P_W-1:0]             psum;

  // valid shift with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], acc};
    end
  end

  assign qpad = (wlb_pkg::QCH*wlb_pkg::HW)'(q4_r);

  // column sum of the partial product rows
  always_comb begin
    psum = '0;
    for (int i = 0; i < wlb_pkg::QCH; i++) begin
      psum = psum + (wlb_pkg::P_W'(row6_r[i]) << (wlb_pkg::HW * i));
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      bad1_r <= (n == '0) || (s > n);
      s1_r   <= s;
      n1_r   <= n;
      d1_r   <= n - s;
      z2_1_r <= z * z;

      bad2_r <= bad1_r;
      sd2_r  <= s1_r * d1_r;
      nzl2_r <= n1_r * z2_1_r[wlb_pkg::HW-1:0];
      nzh2_r <= n1_r * z2_1_r[wlb_pkg::Z2_W-1:wlb_pkg::HW];
      se2_r  <= s1_r * wlb_pkg::PPM_SQ;
      ne2_r  <= n1_r * wlb_pkg::PPM_SQ;
      z2_2_r <= z2_1_r;
      n2_r   <= n1_r;

      bad3_r <= bad2_r;
      bl3_r  <= sd2_r[wlb_pkg::CNT_W-1:0] * wlb_pkg::PPM_SQ;
      bh3_r  <= sd2_r[wlb_pkg::SD_W-1:wlb_pkg::CNT_W] * wlb_pkg::PPM_SQ;
      nz3_r  <= wlb_pkg::NZ_W'(nzl2_r) + (wlb_pkg::NZ_W'(nzh2_r) << wlb_pkg::HW);
      x3_r   <= (wlb_pkg::X_W'(se2_r) << (wlb_pkg::FRAC_W + 1))
              + (wlb_pkg::X_W'(z2_2_r) << wlb_pkg::FRAC_W);
      c3_r   <= (wlb_pkg::C_W'(ne2_r) << 1) + (wlb_pkg::C_W'(z2_2_r) << 1);
      z2_3_r <= z2_2_r;
      n3_r   <= n2_r;

      bad4_r <= bad3_r;
      q4_r   <= (wlb_pkg::Q_W'(bh3_r) << (wlb_pkg::CNT_W + 2))
              + (wlb_pkg::Q_W'(bl3_r) << 2) + wlb_pkg::Q_W'(nz3_r);
      x4_r   <= x3_r;
      c4_r   <= c3_r;
      z2_4_r <= z2_3_r;
      n4_r   <= n3_r;

      bad5_r <= bad4_r;
      for (int i = 0; i < wlb_pkg::QCH; i++) begin
        ppl5_r[i] <= qpad[wlb_pkg::HW*i +: wlb_pkg::HW] * z2_4_r[wlb_pkg::HW-1:0];
        pph5_r[i] <= qpad[wlb_pkg::HW*i +: wlb_pkg::HW]
                   * z2_4_r[wlb_pkg::Z2_W-1:wlb_pkg::HW];
      end
      x5_r   <= x4_r;
      c5_r   <= c4_r;
      n5_r   <= n4_r;

      bad6_r <= bad5_r;
      for (int i = 0; i < wlb_pkg::QCH; i++) begin
        row6_r[i] <= wlb_pkg::ROW_W'(ppl5_r[i])
                   + (wlb_pkg::ROW_W'(pph5_r[i]) << wlb_pkg::HW);
      end
      x6_r   <= x5_r;
      c6_r   <= c5_r;
      n6_r   <= n5_r;

      bad7_r <= bad6_r;
      p7_r   <= psum;
      x7_r   <= x6_r;
      c7_r   <= c6_r;
      n7_r   <= n6_r;
    end
  end

  // dividend is the product scaled by the squared fraction weight
  always_comb begin
    f_o.sd.vld = v_r[6];
    f_o.sd.bad = bad7_r;
    f_o.sd.x   = x7_r;
    f_o.sd.c   = c7_r;
    f_o.n      = n7_r;
    f_o.rem    = '0;
    f_o.sh     = {p7_r, {(2*wlb_pkg::FRAC_W){1'b0}}};
  end

endmodule

[design/wlb_div_cell.sv]
module wlb_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  wlb_pkg::div_t d_i,
  output wlb_pkg::div_t d_o
);

  logic                  vld_r;
  wlb_pkg::div_t         st_r, st_nxt;
  logic [wlb_pkg::CNT_W:0] t, dif;
  logic                  ge;

  // one quotient bit: bring down the next dividend bit and try the divisor
  always_comb begin
    t      = {d_i.rem, d_i.sh[wlb_pkg::M_W-1]};
    dif    = t - {1'b0, d_i.n};
    ge     = (t >= {1'b0, d_i.n});
    st_nxt = d_i;
    st_nxt.rem = ge ? dif[wlb_pkg::CNT_W-1:0] : t[wlb_pkg::CNT_W-1:0];
    st_nxt.sh  = {d_i.sh[wlb_pkg::M_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.sd.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    d_o        = st_r;
    d_o.sd.vld = vld_r;
  end

endmodule

[design/wlb_sqrt_cell.sv]
module wlb_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  wlb_pkg::sqrt_t d_i,
  output wlb_pkg::sqrt_t d_o
);

  logic                       vld_r;
  wlb_pkg::sqrt_t             st_r, st_nxt;
  logic [wlb_pkg::RM_W+1:0]   t, trial, dif;
  logic                       ge;

  // one root bit: bring down two radicand bits, try 4r+1
  always_comb begin
    t      = {d_i.rem, d_i.rad[wlb_pkg::RAD_W-1 -: 2]};
    trial  = (wlb_pkg::RM_W+2)'({d_i.root, 2'b01});
    dif    = t - trial;
    ge     = (t >= trial);
    st_nxt = d_i;
    st_nxt.rem  = ge ? dif[wlb_pkg::RM_W-1:0] : t[wlb_pkg::RM_W-1:0];
    st_nxt.root = {d_i.root[wlb_pkg::SQ_W-2:0], ge};
    st_nxt.rad  = {d_i.rad[wlb_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.sd.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    d_o        = st_r;
    d_o.sd.vld = vld_r;
  end

endmodule

[design/wlb_qdiv_cell.sv]
module wlb_qdiv_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  wlb_pkg::qd_t d_i,
  output wlb_pkg::qd_t d_o
);

  logic        vld_r;
  wlb_pkg::qd_t st_r, st_nxt;
  logic        ge;

  // one quotient bit against a divisor that halves every cell
  always_comb begin
    ge     = (d_i.rem >= d_i.dv);
    st_nxt = d_i;
    st_nxt.rem = ge ? (d_i.rem - d_i.dv) : d_i.rem;
    st_nxt.dv  = d_i.dv >> 1;
    st_nxt.q   = {d_i.q[wlb_pkg::QO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.sd.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    d_o        = st_r;
    d_o.sd.vld = vld_r;
  end

endmodule

[design/wilson_lower_bound_unit.sv]
// Wilson score lower bound of a success proportion, one request per cycle.
// in_req carries success_count and trial_count; out_res returns
// lower_bound_frac (fraction scaled by 2^32, truncated, saturated just
// below one) and input_invalid (zero trials or successes above trials,
// bound then zero). cfg_we/cfg_wdata write z in millionths; write it only
// while no request is in flight.
// From acceptance to out_res.valid a request passes through 7 multiply
// stages, 217 cells dividing by the trial count (one dividend bit each),
// a ceiling stage, 93 square root cells (one root bit each), a subtract
// stage, 33 cells for the final quotient and a two-entry output buffer.
// Throughput is one request per cycle. Reset clears all valid bits and
// loads z = 1.96. When the receiver stalls, the output buffer keeps
// accepting until both entries are full and a finished result reaches the
// end of the chain; then the whole chain holds and in_req.ready drops.
module wilson_lower_bound_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  wlb_in_if.sink                  in_req,
  wlb_out_if.source               out_res,
  input  logic                    cfg_we,
  input  logic [wlb_pkg::Z_W-1:0] cfg_wdata
);

  logic [wlb_pkg::Z_W-1:0] z_r;
  logic                    en, acc, push, pop;
  logic [1:0]              cnt_r;
  wlb_pkg::res_t           b0_r, b1_r, res_in;

  wlb_pkg::div_t  dch [wlb_pkg::M_W+1];
  wlb_pkg::sqrt_t sch [wlb_pkg::SQ_W+1];
  wlb_pkg::qd_t   qch [wlb_pkg::QO_W+1];

  logic                  cs_vld_r, fn_vld_r;
  wlb_pkg::sqrt_t        cs_r, cs_nxt;
  wlb_pkg::qd_t          fn_r, fn_nxt;
  logic [wlb_pkg::T_W-1:0] t_ceil;
  logic [wlb_pkg::X_W-1:0] t_ext;

  // z register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_r <= wlb_pkg::Z_RESET;
    end else if (cfg_we) begin
      z_r <= cfg_wdata;
    end
  end

  // chain advances unless a finished result has nowhere to go
  assign en           = !(qch[wlb_pkg::QO_W].sd.vld && (cnt_r == 2'd2));
  assign in_req.ready = en;
  assign acc          = in_req.valid && en;

  wlb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .acc   (acc),
    .s     (in_req.success_count),
    .n     (in_req.trial_count),
    .z     (z_r),
    .f_o   (dch[0])
  );

  // divide the scaled product by the trial count
  for (genvar i = 0; i < wlb_pkg::M_W; i++) begin : g_div
    wlb_div_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (en), .d_i (dch[i]), .d_o (dch[i+1])
    );
  end

  // round the quotient up to form the radicand
  always_comb begin
    cs_nxt.sd   = dch[wlb_pkg::M_W].sd;
    cs_nxt.rad  = wlb_pkg::RAD_W'(dch[wlb_pkg::M_W].sh[wlb_pkg::U_W-1:0])
                + wlb_pkg::RAD_W'(dch[wlb_pkg::M_W].rem != '0);
    cs_nxt.rem  = '0;
    cs_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_vld_r <= 1'b0;
    end else if (en) begin
      cs_vld_r <= cs_nxt.sd.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_nxt;
    end
  end

  always_comb begin
    sch[0]        = cs_r;
    sch[0].sd.vld = cs_vld_r;
  end

  // square root of the radicand
  for (genvar i = 0; i < wlb_pkg::SQ_W; i++) begin : g_sqrt
    wlb_sqrt_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (en), .d_i (sch[i]), .d_o (sch[i+1])
    );
  end

  // ceiling of the root, numerator minus root, clipped at zero
  always_comb begin
    t_ceil = wlb_pkg::T_W'(sch[wlb_pkg::SQ_W].root)
           + wlb_pkg::T_W'(sch[wlb_pkg::SQ_W].rem != '0);
    t_ext  = wlb_pkg::X_W'(t_ceil);
    fn_nxt.sd  = sch[wlb_pkg::SQ_W].sd;
    fn_nxt.rem = (sch[wlb_pkg::SQ_W].sd.x > t_ext) ?
                 (sch[wlb_pkg::SQ_W].sd.x - t_ext) : '0;
    fn_nxt.dv  = {sch[wlb_pkg::SQ_W].sd.c, {wlb_pkg::FRAC_W{1'b0}}};
    fn_nxt.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_vld_r <= 1'b0;
    end else if (en) begin
      fn_vld_r <= fn_nxt.sd.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn_r <= fn_nxt;
    end
  end

  always_comb begin
    qch[0]        = fn_r;
    qch[0].sd.vld = fn_vld_r;
  end

  // final quotient over the denominator
  for (genvar i = 0; i < wlb_pkg::QO_W; i++) begin : g_qdiv
    wlb_qdiv_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (en), .d_i (qch[i]), .d_o (qch[i+1])
    );
  end

  // saturate a bound of one, zero for rejected inputs
  always_comb begin
    res_in.bad  = qch[wlb_pkg::QO_W].sd.bad;
    res_in.frac = qch[wlb_pkg::QO_W].sd.bad ? '0 :
                  (qch[wlb_pkg::QO_W].q[wlb_pkg::QO_W-1] ? '1 :
                   qch[wlb_pkg::QO_W].q[wlb_pkg::FRAC_W-1:0]);
  end

  // two-entry output buffer
  assign push = en && qch[wlb_pkg::QO_W].sd.vld;
  assign pop  = out_res.valid && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case (cnt_r)
        2'd0: begin
          if (push) cnt_r <= 2'd1;
        end
        2'd1: begin
          if (push && !pop) cnt_r <= 2'd2;
          else if (!push && pop) cnt_r <= 2'd0;
        end
        2'd2: begin
          if (pop) cnt_r <= 2'd1;
        end
        default: cnt_r <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cnt_r)
      2'd0: begin
        if (push) b0_r <= res_in;
      end
      2'd1: begin
        if (push && pop) b0_r <= res_in;
        else if (push) b1_r <= res_in;
      end
      2'd2: begin
        if (pop) b0_r <= b1_r;
      end
      default: b0_r <= res_in;
    endcase
  end

  assign out_res.valid            = (cnt_r != 2'd0);
  assign out_res.lower_bound_frac = b0_r.frac;
  assign out_res.input_invalid    = b0_r.bad;

endmodule

[design/wlb_checker.sv]
`include "wilson_lower_bound_unit_defines.svh"

module wlb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [wlb_pkg::FRAC_W-1:0] out_frac,
  input logic                       out_invalid
);

  // a stalled result stays offered
  `WLB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its value
  `WLB_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_frac) && $stable(out_invalid))

  // rejected inputs give a zero bound
  `WLB_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && out_invalid, out_frac == '0)

  // with the output buffer empty the input side never stalls
  `WLB_ASSERT_IMP(a_ready_empty, clk, rst_n, !out_valid, in_ready)

  // after a request is accepted with the output buffer empty, the input side still does not stall
  `WLB_ASSERT_NXT(a_ready_hold, clk, rst_n, in_valid && in_ready && !out_valid, in_ready)

endmodule

bind wilson_lower_bound_unit wlb_checker u_wlb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_frac    (out_res.lower_bound_frac),
  .out_invalid (out_res.input_invalid)
);

[tb/tb_top.sv]
// expected result of one request
typedef struct {
  logic [31:0] frac;
  logic        bad;
  logic [31:0] s;
  logic [31:0] n;
} bound_t;

// holds the expected bounds and checks the returned ones in order
class bound_board;
  logic [23:0] z_ppm;
  bound_t      pending[$];
  int          mismatches;
  int          checked;

  function new();
    z_ppm = wlb_pkg::Z_RESET;
    mismatches = 0;
    checked = 0;
  endfunction

  // exact lower bound, truncated and saturated
  function bound_t wilson_bound(logic [31:0] s, logic [31:0] n);
    bound_t      b;
    bit [255:0]  e, z2, m, u, t, x, c, q, r, cand;
    b.s = s;
    b.n = n;
    b.bad = 0;
    b.frac = '0;
    if (n == 0 || s > n) begin
      b.bad = 1;
      return b;
    end
    e  = 256'd1000000000000;
    z2 = 256'(z_ppm) * 256'(z_ppm);
    m  = (256'd4 * 256'(s) * 256'(n - s) * e + 256'(n) * z2) * z2;
    m  = m << 64;
    u  = m / 256'(n);
    if (m % 256'(n) != 0) u = u + 1;
    // ceiling square root, one bit at a time
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = r | (256'd1 << i);
      if (cand * cand <= u) r = cand;
    end
    t = (r * r == u) ? r : r + 1;
    x = (256'd2 * 256'(s) * e + z2) << 32;
    c = 256'd2 * (256'(n) * e + z2);
    if (x > t) begin
      q = (x - t) / c;
      if (q >= (256'd1 << 32)) q = (256'd1 << 32) - 1;
      b.frac = q[31:0];
    end
    return b;
  endfunction

  function void note_request(logic [31:0] s, logic [31:0] n);
    pending.push_back(wilson_bound(s, n));
  endfunction

  task report(string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  task check_result(logic [31:0] frac, logic bad);
    bound_t b;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result frac=%h bad=%b", frac, bad));
      return;
    end
    b = pending.pop_front();
    checked++;
    if (frac !== b.frac)
      report($sformatf("s=%0d n=%0d z=%0d frac %h, want %h", b.s, b.n, z_ppm, frac, b.frac));
    if (bad !== b.bad)
      report($sformatf("s=%0d n=%0d invalid %b, want %b", b.s, b.n, bad, b.bad));
  endtask
endclass

module tb_top;
  localparam int LIMIT = 600000;
  localparam int DRAIN = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  int          cycles;
  int          sent;
  bit          hold_long;
  bound_board  board;

  wlb_in_if  in_if();
  wlb_out_if out_if();

  wilson_lower_bound_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if),
    .out_res   (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.check_result(out_if.lower_bound_frac, out_if.input_invalid);
  end

  // gap length: mostly short, a few long
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // receiver back-pressure
  initial begin
    int len;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_if.ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_long = 0;
      end
      len = $urandom_range(1, 60);
      out_if.ready <= 1'b1;
      repeat (len) @(posedge clk);
      len = gap_len();
      if (len > 0) begin
        out_if.ready <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  // offer one request and wait for acceptance
  task automatic send_pair(logic [31:0] s, logic [31:0] n);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.success_count <= s;
    in_if.trial_count <= n;
    do @(posedge clk); while (!in_if.ready);
    board.note_request(s, n);
    sent++;
  endtask

  // stop offering and let every result come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_z(logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.z_ppm = v;
    @(posedge clk);
  endtask

  // random pair, mostly well-formed over a spread of magnitudes
  task automatic send_random();
    logic [31:0] s, n, mask;
    logic [63:0] w;
    int k, bits;
    k = $urandom_range(0, 99);
    bits = $urandom_range(1, 32);
    mask = (bits == 32) ? 32'hffffffff : ((32'd1 << bits) - 1);
    n = $urandom & mask;
    if (k < 4) begin
      send_pair($urandom, 32'd0);
    end else if (k < 10) begin
      if (n == 32'hffffffff) n = n - 1;
      w = {$urandom, $urandom} % (64'h100000000 - 64'(n) - 1);
      send_pair(n + 1 + w[31:0], n);
    end else begin
      if (n == 0) n = 1;
      k = $urandom_range(0, 9);
      if (k == 0) s = 0;
      else if (k == 1) s = n;
      else begin
        w = {$urandom, $urandom} % (64'(n) + 1);
        s = w[31:0];
      end
      send_pair(s, n);
    end
  endtask

  task automatic random_phase(int count);
    repeat (count) send_random();
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.success_count = '0;
    in_if.trial_count = '0;
    cycles = 0;
    sent = 0;
    hold_long = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset z, extremes and rejected inputs
    send_pair(32'd0, 32'd0);
    send_pair(32'hffffffff, 32'd0);
    send_pair(32'd5, 32'd4);
    send_pair(32'hffffffff, 32'hfffffffe);
    send_pair(32'd0, 32'd1);
    send_pair(32'd1, 32'd1);
    send_pair(32'd0, 32'hffffffff);
    send_pair(32'hffffffff, 32'hffffffff);
    send_pair(32'd1, 32'hffffffff);
    send_pair(32'h7fffffff, 32'hffffffff);
    send_pair(32'd50, 32'd100);
    send_pair(32'haaaaaaaa, 32'hd5555555);
    send_pair(32'h55555555, 32'h55555555);

    // random with a long receiver stall part way through
    random_phase(100);
    hold_long = 1;
    random_phase(300);
    drain();

    // zero z: plain ratio, bound clamped at s = n
    write_z(24'd0);
    send_pair(32'd7, 32'd7);
    send_pair(32'hffffffff, 32'hffffffff);
    send_pair(32'd1, 32'd3);
    send_pair(32'd0, 32'd9);
    random_phase(150);
    drain();

    // largest z
    write_z(24'hffffff);
    send_pair(32'd1, 32'd1);
    send_pair(32'hffffffff, 32'hffffffff);
    send_pair(32'd0, 32'd1);
    random_phase(200);
    drain();

    // a few random z values
    repeat (3) begin
      write_z(24'($urandom));
      random_phase(100);
      drain();
    end

    write_z(24'd1);
    random_phase(150);
    drain();

    write_z(24'd1000000);
    random_phase(120);
    drain();

    write_z(24'd1960000);
    random_phase(130);
    drain();

    $display("sent %0d requests, checked %0d results over several z settings",
             sent, board.checked);
    $display("covered rejected inputs, zero and full-scale z, and a long output stall");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
